### design/assert_macros.svh
// Assertion helpers shared by the RTL. Each macro expands to a labeled
// concurrent assertion in simulation and to nothing in synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/scp_pkg.sv
package scp_pkg;

    localparam int NUM_STATES = 7;
    localparam int STATE_W    = 3;
    localparam int COUNT_W    = 11;
    localparam int EDGES_MAX  = 3;
    localparam int EDGE_W     = 2;
    localparam int LFSR_W     = 32;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED      = 1'b1;

    localparam logic [COUNT_W-1:0]    CHANNEL_COUNT_RST = 11'd1024;
    localparam logic [CFG_DATA_W-1:0] RNG_SEED_RST      = 32'd1;

    typedef logic [STATE_W-1:0] t_state_idx;
    typedef logic [EDGE_W-1:0]  t_edge_idx;

    localparam t_state_idx ST_1 = 3'd0;
    localparam t_state_idx ST_2 = 3'd1;
    localparam t_state_idx ST_3 = 3'd2;
    localparam t_state_idx ST_4 = 3'd3;
    localparam t_state_idx ST_5 = 3'd4;
    localparam t_state_idx ST_6 = 3'd5;
    localparam t_state_idx ST_7 = 3'd6;

    typedef enum logic [2:0] {
        OP_IDLE,
        OP_EDGE,
        OP_SUM1,
        OP_SUM2,
        OP_LOAD,
        OP_DRAW,
        OP_OUT,
        OP_INIT
    } t_op;

    localparam int PC_W = 5;
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_START = 5'd0;
    localparam t_pc PC_OUT   = 5'd18;
    localparam t_pc PC_INIT  = 5'd19;

    typedef struct packed {
        t_op        op;
        t_state_idx st;
        t_pc        tgt;
    } t_uop;

    // Microprogram: wait for an item, build thresholds, then a load and a draw
    // loop per state in turn, or reinitialize instead; then publish the counts.
    function automatic t_uop ucode(input t_pc pc);
        t_uop u;
        case (pc)
            5'd0:    u = '{op: OP_IDLE, st: ST_1, tgt: PC_INIT};
            5'd1:    u = '{op: OP_EDGE, st: ST_1, tgt: PC_START};
            5'd2:    u = '{op: OP_SUM1, st: ST_1, tgt: PC_START};
            5'd3:    u = '{op: OP_SUM2, st: ST_1, tgt: PC_START};
            5'd4:    u = '{op: OP_LOAD, st: ST_1, tgt: PC_START};
            5'd5:    u = '{op: OP_DRAW, st: ST_1, tgt: PC_START};
            5'd6:    u = '{op: OP_LOAD, st: ST_2, tgt: PC_START};
            5'd7:    u = '{op: OP_DRAW, st: ST_2, tgt: PC_START};
            5'd8:    u = '{op: OP_LOAD, st: ST_3, tgt: PC_START};
            5'd9:    u = '{op: OP_DRAW, st: ST_3, tgt: PC_START};
            5'd10:   u = '{op: OP_LOAD, st: ST_4, tgt: PC_START};
            5'd11:   u = '{op: OP_DRAW, st: ST_4, tgt: PC_START};
            5'd12:   u = '{op: OP_LOAD, st: ST_5, tgt: PC_START};
            5'd13:   u = '{op: OP_DRAW, st: ST_5, tgt: PC_START};
            5'd14:   u = '{op: OP_LOAD, st: ST_6, tgt: PC_START};
            5'd15:   u = '{op: OP_DRAW, st: ST_6, tgt: PC_START};
            5'd16:   u = '{op: OP_LOAD, st: ST_7, tgt: PC_START};
            5'd17:   u = '{op: OP_DRAW, st: ST_7, tgt: PC_START};
            5'd18:   u = '{op: OP_OUT,  st: ST_1, tgt: PC_START};
            5'd19:   u = '{op: OP_INIT, st: ST_1, tgt: PC_OUT};
            default: u = '{op: OP_IDLE, st: ST_1, tgt: PC_START};
        endcase
        return u;
    endfunction

    // Target state of each threshold. Unused slots repeat the last threshold
    // of their state, so their target is never taken.
    function automatic t_state_idx edge_dest(input t_state_idx s, input t_edge_idx e);
        t_state_idx d;
        d = s;
        case (s)
            ST_1: d = ST_2;
            ST_2: d = (e == 2'd0) ? ST_3 : ST_1;
            ST_3: d = (e == 2'd0) ? ST_4 : ((e == 2'd1) ? ST_6 : ST_2);
            ST_4: d = (e == 2'd0) ? ST_5 : ((e == 2'd1) ? ST_6 : ST_3);
            ST_5: d = (e == 2'd0) ? ST_7 : ST_4;
            ST_6: d = (e == 2'd0) ? ST_3 : ((e == 2'd1) ? ST_4 : ST_7);
            ST_7: d = (e == 2'd0) ? ST_6 : ST_5;
            default: d = s;
        endcase
        return d;
    endfunction

endpackage

### design/scp_if.sv
interface scp_in_if #(parameter int PROB_BITS = 16);
    logic                 valid;
    logic                 ready;
    logic                 kind;
    logic [PROB_BITS-1:0] kappa_prob;
    logic [PROB_BITS-1:0] lambda_prob;
    logic [PROB_BITS-1:0] alpha_m_prob;
    logic [PROB_BITS-1:0] beta_m_prob;
    logic [PROB_BITS-1:0] alpha_h_prob;
    logic [PROB_BITS-1:0] beta_h_prob;
    logic [PROB_BITS-1:0] gamma_prob;
    logic [PROB_BITS-1:0] delta_prob;
    logic [PROB_BITS-1:0] k_ic_prob;
    logic [PROB_BITS-1:0] k_ci_prob;

    modport source (
        output valid, kind, kappa_prob, lambda_prob, alpha_m_prob, beta_m_prob,
               alpha_h_prob, beta_h_prob, gamma_prob, delta_prob, k_ic_prob, k_ci_prob,
        input  ready
    );
    modport sink (
        input  valid, kind, kappa_prob, lambda_prob, alpha_m_prob, beta_m_prob,
               alpha_h_prob, beta_h_prob, gamma_prob, delta_prob, k_ic_prob, k_ci_prob,
        output ready
    );
endinterface

interface scp_out_if import scp_pkg::*; ;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] count_s1;
    logic [COUNT_W-1:0] count_s2;
    logic [COUNT_W-1:0] count_s3;
    logic [COUNT_W-1:0] count_s4;
    logic [COUNT_W-1:0] count_s5;
    logic [COUNT_W-1:0] count_s6;
    logic [COUNT_W-1:0] count_s7;

    modport source (
        output valid, count_s1, count_s2, count_s3, count_s4, count_s5, count_s6,
               count_s7,
        input  ready
    );
    modport sink (
        input  valid, count_s1, count_s2, count_s3, count_s4, count_s5, count_s6,
               count_s7,
        output ready
    );
endinterface

interface scp_cfg_if import scp_pkg::*; ;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### design/stochastic_channel_population_step.sv
// Seven-state channel population stepped by Monte Carlo draws.
// Channels: i_in carries one item per beat (kind plus ten Q0.16 transition
// probabilities), o_out returns the seven state counts, one beat per item,
// and i_cfg writes channel_count (index 0) or rng_seed (index 1); it is
// always ready. Items are handled one at a time by a microcoded sequencer
// whose program sits in a constant table in the package.
// A reinitialize item goes from its beat through the init step to publish.
// In a time step the draw loop makes one draw per cycle, while draws for the
// state remain, through a single LFSR and compare unit; each state has a
// load step for its counter, and a state that starts the step empty still
// passes once through its draw step.
// The next input beat can be taken from the cycle after the result is loaded into
// the output register, so a result may wait there while the next item runs.
// If the receiver stalls with a result still held, the block stops at its
// publish step until that beat is taken.
// After reset state one holds MAX_CHANNELS channels, the generator holds
// one, channel_count is 1024 and rng_seed is one.
module stochastic_channel_population_step
    import scp_pkg::*;
#(
    parameter int MAX_CHANNELS = 1024,
    parameter int PROB_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scp_in_if.sink        i_in,
    scp_cfg_if.sink       i_cfg,
    scp_out_if.source     o_out
);

`include "assert_macros.svh"

    localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
    localparam int EXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int THR_W  = PROB_BITS + 1;
    localparam int WIDE_W = PROB_BITS + 3;
    localparam logic [WIDE_W-1:0] PROB_ONE = {{(WIDE_W-1){1'b0}}, 1'b1} << PROB_BITS;

    typedef logic [PROB_BITS-1:0] t_prob;
    typedef logic [THR_W-1:0]     t_thr;
    typedef logic [CNT_W-1:0]     t_cnt;

    function automatic t_thr sat_one(input logic [WIDE_W-1:0] v);
        return (v > PROB_ONE) ? PROB_ONE[THR_W-1:0] : v[THR_W-1:0];
    endfunction

    function automatic t_thr sat_add(input t_thr a, input t_thr b);
        return sat_one(WIDE_W'(a) + WIDE_W'(b));
    endfunction

    // Configuration registers
    logic [COUNT_W-1:0]    r_chan;
    logic [CFG_DATA_W-1:0] r_seed;

    // Sequencer
    t_pc  r_pc;
    t_pc  n_pc;
    t_uop w_uop;
    logic w_in_ready;
    logic w_out_load;

    // Captured probabilities
    t_prob r_kap, r_lam, r_am, r_bm, r_ah, r_bh, r_gam, r_del, r_kic, r_kci;

    // Edge probabilities and thresholds
    t_thr r_p12, r_p21, r_p23, r_p32, r_p34, r_p43;
    t_thr r_p45, r_p54, r_p36, r_p63, r_p46, r_p64;
    t_thr r_thr [NUM_STATES][EDGES_MAX];

    // Population
    t_cnt              r_cnt  [NUM_STATES];
    t_cnt              r_snap [NUM_STATES];
    t_cnt              r_left;
    logic [LFSR_W-1:0] r_lfsr;

    // Output register
    logic               r_out_valid;
    logic [COUNT_W-1:0] r_out [NUM_STATES];

    // Draw datapath
    logic [LFSR_W-1:0] w_lfsr_nx;
    t_thr              w_draw;
    logic              w_move;
    t_edge_idx         w_edge;
    t_state_idx        w_cur;
    t_state_idx        w_dst;
    t_cnt              w_init_n;
    logic [CNT_W+2:0]  w_cnt_sum;

    assign w_uop = ucode(r_pc);
    assign w_cur = w_uop.st;

    always_comb begin
        w_lfsr_nx = r_lfsr >> 1;
        if (r_lfsr[0]) begin
            w_lfsr_nx = w_lfsr_nx ^ LFSR_TAPS;
        end
        w_draw = THR_W'(w_lfsr_nx[LFSR_W-1 -: PROB_BITS]);
    end

    // First threshold that the draw falls below wins.
    always_comb begin
        w_move = 1'b1;
        w_edge = 2'd0;
        if (w_draw < r_thr[w_cur][0]) begin
            w_edge = 2'd0;
        end else if (w_draw < r_thr[w_cur][1]) begin
            w_edge = 2'd1;
        end else if (w_draw < r_thr[w_cur][2]) begin
            w_edge = 2'd2;
        end else begin
            w_move = 1'b0;
        end
        w_dst = edge_dest(w_cur, w_edge);
    end

    assign w_init_n = (EXT_W'(r_chan) > EXT_W'(MAX_CHANNELS)) ?
                      CNT_W'(MAX_CHANNELS) : CNT_W'(r_chan);

    always_comb begin
        w_cnt_sum = '0;
        for (int s = 0; s < NUM_STATES; s++) begin
            w_cnt_sum = w_cnt_sum + (CNT_W + 3)'(r_cnt[s]);
        end
    end

    // Sequencer next address and handshake strobes
    always_comb begin
        n_pc       = r_pc;
        w_in_ready = 1'b0;
        w_out_load = 1'b0;
        case (w_uop.op)
            OP_IDLE: begin
                w_in_ready = 1'b1;
                if (i_in.valid) begin
                    n_pc = i_in.kind ? w_uop.tgt : t_pc'(r_pc + 1'b1);
                end
            end
            OP_EDGE, OP_SUM1, OP_SUM2, OP_LOAD: begin
                n_pc = t_pc'(r_pc + 1'b1);
            end
            OP_DRAW: begin
                if (r_left <= t_cnt'(1)) begin
                    n_pc = t_pc'(r_pc + 1'b1);
                end
            end
            OP_OUT: begin
                if (!r_out_valid || o_out.ready) begin
                    w_out_load = 1'b1;
                    n_pc       = w_uop.tgt;
                end
            end
            OP_INIT: begin
                n_pc = w_uop.tgt;
            end
            default: begin
                n_pc = PC_START;
            end
        endcase
    end

    assign i_in.ready  = w_in_ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid    = r_out_valid;
    assign o_out.count_s1 = r_out[ST_1];
    assign o_out.count_s2 = r_out[ST_2];
    assign o_out.count_s3 = r_out[ST_3];
    assign o_out.count_s4 = r_out[ST_4];
    assign o_out.count_s5 = r_out[ST_5];
    assign o_out.count_s6 = r_out[ST_6];
    assign o_out.count_s7 = r_out[ST_7];

    // Control state, configuration and population
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_START;
            r_out_valid <= 1'b0;
            r_chan      <= CHANNEL_COUNT_RST;
            r_seed      <= RNG_SEED_RST;
            r_lfsr      <= {{(LFSR_W-1){1'b0}}, 1'b1};
            r_left      <= '0;
            for (int s = 0; s < NUM_STATES; s++) begin
                r_cnt[s]  <= '0;
                r_snap[s] <= '0;
            end
            r_cnt[ST_1] <= CNT_W'(MAX_CHANNELS);
        end else begin
            r_pc <= n_pc;

            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_CHANNEL_COUNT: r_chan <= i_cfg.data[COUNT_W-1:0];
                    CFG_RNG_SEED:      r_seed <= i_cfg.data;
                    default:           r_seed <= r_seed;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            case (w_uop.op)
                OP_EDGE: begin
                    for (int s = 0; s < NUM_STATES; s++) begin
                        r_snap[s] <= r_cnt[s];
                    end
                end
                OP_LOAD: begin
                    r_left <= r_snap[w_cur];
                end
                OP_DRAW: begin
                    if (r_left != '0) begin
                        r_lfsr <= w_lfsr_nx;
                        r_left <= r_left - 1'b1;
                        if (w_move) begin
                            r_cnt[w_cur] <= r_cnt[w_cur] - 1'b1;
                            r_cnt[w_dst] <= r_cnt[w_dst] + 1'b1;
                        end
                    end
                end
                OP_INIT: begin
                    for (int s = 0; s < NUM_STATES; s++) begin
                        r_cnt[s] <= '0;
                    end
                    r_cnt[ST_1] <= w_init_n;
                    r_lfsr      <= (r_seed == '0) ? {{(LFSR_W-1){1'b0}}, 1'b1} : r_seed;
                end
                default: begin
                    r_left <= r_left;
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_in.valid) begin
            r_kap <= i_in.kappa_prob;
            r_lam <= i_in.lambda_prob;
            r_am  <= i_in.alpha_m_prob;
            r_bm  <= i_in.beta_m_prob;
            r_ah  <= i_in.alpha_h_prob;
            r_bh  <= i_in.beta_h_prob;
            r_gam <= i_in.gamma_prob;
            r_del <= i_in.delta_prob;
            r_kic <= i_in.k_ic_prob;
            r_kci <= i_in.k_ci_prob;
        end

        if (w_out_load) begin
            for (int s = 0; s < NUM_STATES; s++) begin
                r_out[s] <= COUNT_W'(EXT_W'(r_cnt[s]));
            end
        end

        case (w_uop.op)
            OP_EDGE: begin
                r_p12 <= sat_one(WIDE_W'(r_kap) << 2);
                r_p21 <= sat_one(WIDE_W'(r_lam));
                r_p23 <= sat_one(WIDE_W'(r_am) + (WIDE_W'(r_am) << 1));
                r_p32 <= sat_one(WIDE_W'(r_bm) << 1);
                r_p34 <= sat_one(WIDE_W'(r_am) << 1);
                r_p43 <= sat_one(WIDE_W'(r_bm) + (WIDE_W'(r_bm) << 1));
                r_p45 <= sat_one(WIDE_W'(r_del));
                r_p54 <= sat_one(WIDE_W'(r_gam) << 2);
                r_p36 <= sat_one(WIDE_W'(r_kci));
                r_p63 <= sat_one(WIDE_W'(r_kic));
                r_p46 <= sat_one(WIDE_W'(r_bh));
                r_p64 <= sat_one(WIDE_W'(r_ah));
            end
            OP_SUM1: begin
                // The last slot copies the slot before it; states ST_3, ST_4 and
                // ST_6 overwrite it with their full sum in the SUM2 step.
                r_thr[ST_1][0] <= r_p12;
                r_thr[ST_1][1] <= r_p12;
                r_thr[ST_1][2] <= r_p12;
                r_thr[ST_2][0] <= r_p23;
                r_thr[ST_2][1] <= sat_add(r_p23, r_p21);
                r_thr[ST_2][2] <= sat_add(r_p23, r_p21);
                r_thr[ST_3][0] <= r_p34;
                r_thr[ST_3][1] <= sat_add(r_p34, r_p36);
                r_thr[ST_3][2] <= sat_add(r_p34, r_p36);
                r_thr[ST_4][0] <= r_p45;
                r_thr[ST_4][1] <= sat_add(r_p45, r_p46);
                r_thr[ST_4][2] <= sat_add(r_p45, r_p46);
                r_thr[ST_5][0] <= r_p46;
                r_thr[ST_5][1] <= sat_add(r_p46, r_p54);
                r_thr[ST_5][2] <= sat_add(r_p46, r_p54);
                r_thr[ST_6][0] <= r_p63;
                r_thr[ST_6][1] <= sat_add(r_p63, r_p64);
                r_thr[ST_6][2] <= sat_add(r_p63, r_p64);
                r_thr[ST_7][0] <= r_p54;
                r_thr[ST_7][1] <= sat_add(r_p54, r_p64);
                r_thr[ST_7][2] <= sat_add(r_p54, r_p64);
            end
            OP_SUM2: begin
                r_thr[ST_3][2] <= sat_add(r_thr[ST_3][1], r_p32);
                r_thr[ST_4][2] <= sat_add(r_thr[ST_4][1], r_p43);
                r_thr[ST_6][2] <= sat_add(r_thr[ST_6][1], r_p45);
            end
            default: begin
                r_p12 <= r_p12;
            end
        endcase
    end

    // Channels only move between states; only a reinitialize changes the total.
    `ASSERT_CLK(a_population_kept, i_clk, i_rst_n,
        (w_uop.op != OP_INIT) |=> $stable(w_cnt_sum), "population changed during a step")

    // A pending draw always has a channel left in the state being drawn.
    `ASSERT_CLK(a_no_underflow, i_clk, i_rst_n,
        (w_uop.op == OP_DRAW) && (r_left != '0) |-> (r_cnt[w_cur] != '0),
        "draw from an empty state")

    // Cumulative thresholds never fall along a state's edge list.
    `ASSERT_CLK(a_thr_monotone, i_clk, i_rst_n,
        (w_uop.op == OP_DRAW) |->
            (r_thr[w_cur][0] <= r_thr[w_cur][1]) && (r_thr[w_cur][1] <= r_thr[w_cur][2]),
        "thresholds out of order")

endmodule
